>>> rtl/motor_resistance_inductance_rls_assert.svh
// Assertion macros for the checker file of the estimator.
`ifndef MOTOR_RESISTANCE_INDUCTANCE_RLS_ASSERT_SVH
`define MOTOR_RESISTANCE_INDUCTANCE_RLS_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during rst.
`define MRIRLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and idle during rst.
`define MRIRLS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mrirls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrirls_pkg
// Types, constants and saturating helpers of the resistance/inductance
// estimator.
// ----------------------------------------------------------------------------
package mrirls_pkg;

  localparam int STATE_W = 48;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_FORGETTING  = 2'd1;
  localparam logic [1:0] CFG_INIT_COV    = 2'd2;
  localparam logic [1:0] CFG_INIT_IND    = 2'd3;

  typedef enum logic [1:0] {ALU_IDLE, ALU_MUL, ALU_DIV, ALU_FIN} alu_state_t;
  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} seq_state_t;

  typedef enum logic [4:0] {
    STEP_PHI1, STEP_T, STEP_Y, STEP_PRED0, STEP_ERR,
    STEP_PP00, STEP_PP0, STEP_PP10, STEP_PP1,
    STEP_Q00, STEP_Q0, STEP_Q10, STEP_Q1,
    STEP_S0, STEP_DEN, STEP_K0, STEP_TH0, STEP_K1, STEP_TH1,
    STEP_M00, STEP_P00, STEP_M01, STEP_P01,
    STEP_M10, STEP_P10, STEP_M11, STEP_P11
  } step_t;

  typedef struct packed {
    logic               start;
    logic               is_div;
    logic               sat_state;
    logic [5:0]         shift;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } alu_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] clamp_state(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[STATE_W-1:0];
    if (v < lo) return lo[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] ext_state(input logic signed [STATE_W-1:0] v);
    return {{(64-STATE_W){v[STATE_W-1]}}, v};
  endfunction

endpackage

>>> rtl/mrirls_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrirls_alu
// Shared sign-magnitude multiply-shift and shift-divide unit with saturation.
// ----------------------------------------------------------------------------
module mrirls_alu (
  input  logic               clk,
  input  logic               rst,
  input  mrirls_pkg::alu_req_t req,
  output mrirls_pkg::alu_rsp_t rsp
);

  mrirls_pkg::alu_state_t state, state_next;
  logic [6:0]   cnt;
  logic         neg, is_div, sat_state;
  logic [5:0]   shift;
  logic [63:0]  ua, ub, rem;
  logic [127:0] num;

  logic [63:0]  ma, mb;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] addend;
  logic [64:0]  rem_sh;
  logic         ge;
  logic [127:0] q;
  logic [63:0]  lim, mag;

  assign ma = req.a[63] ? 64'd0 - req.a : req.a;
  assign mb = req.b[63] ? 64'd0 - req.b : req.b;

  always_comb begin
    pa = cnt[0] ? ua[63:32] : ua[31:0];
    pb = cnt[1] ? ub[63:32] : ub[31:0];
    pp = pa * pb;
    case (cnt[1:0])
      2'd0:    addend = {64'd0, pp};
      2'd3:    addend = {pp, 64'd0};
      default: addend = {32'd0, pp, 32'd0};
    endcase
    rem_sh = {rem, num[127]};
    ge = rem_sh[64] || (rem_sh[63:0] >= ub);
    q = is_div ? num : (num >> shift);
    lim = (64'd1 << (sat_state ? 6'(mrirls_pkg::STATE_W - 1) : 6'd63)) - 64'd1
          + {63'd0, neg};
    mag = (q[127:64] != 64'd0 || q[63:0] > lim) ? lim : q[63:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      mrirls_pkg::ALU_IDLE: if (req.start) begin
        state_next = req.is_div ? mrirls_pkg::ALU_DIV : mrirls_pkg::ALU_MUL;
      end
      mrirls_pkg::ALU_MUL: if (cnt == 7'd3) state_next = mrirls_pkg::ALU_FIN;
      mrirls_pkg::ALU_DIV: if (cnt == 7'd127) state_next = mrirls_pkg::ALU_FIN;
      mrirls_pkg::ALU_FIN: state_next = mrirls_pkg::ALU_IDLE;
      default: state_next = mrirls_pkg::ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mrirls_pkg::ALU_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= (state == mrirls_pkg::ALU_FIN);
      if (state == mrirls_pkg::ALU_FIN) rsp.value <= neg ? 64'd0 - mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mrirls_pkg::ALU_IDLE: begin
        cnt       <= 7'd0;
        neg       <= req.a[63] ^ req.b[63];
        is_div    <= req.is_div;
        sat_state <= req.sat_state;
        shift     <= req.shift;
        ua        <= ma;
        ub        <= mb;
        rem       <= 64'd0;
        num       <= req.is_div ? ({64'd0, ma} << req.shift) : 128'd0;
      end
      mrirls_pkg::ALU_MUL: begin
        cnt <= cnt + 7'd1;
        num <= num + addend;
      end
      mrirls_pkg::ALU_DIV: begin
        cnt <= cnt + 7'd1;
        rem <= ge ? rem_sh[63:0] - ub : rem_sh[63:0];
        num <= {num[126:0], ge};
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/motor_resistance_inductance_rls.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_resistance_inductance_rls
// Two-parameter recursive least squares estimator of stator resistance and
// d-axis inductance with a forgetting factor.
// ----------------------------------------------------------------------------
// Channel  | Signals                          | Contents
// s_*      | s_tvalid s_tready s_tdata[127:0] | voltage_d, current_d, current_q, speed
// m_*      | m_tvalid m_tready m_tdata[63:0]  | resistance_estimate, inductance_estimate
// cfg_*    | cfg_we cfg_addr cfg_data         | four configuration registers
//
// A primed sample takes 21 multiplies and 6 divisions, all on the single shared
// arithmetic unit. The very first sample after reset or restart only stores the
// current and gives no result.
// Reset is synchronous and restores the register defaults and the estimator.
// The block takes a new request whenever it is idle, even while a result is
// still waiting; a finished update then waits until the output slot is free.
// ----------------------------------------------------------------------------
module motor_resistance_inductance_rls (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // voltage_d, current_d, current_q, electrical_speed
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // resistance_estimate, inductance_estimate
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int SW = mrirls_pkg::STATE_W;

  // Configuration registers.
  logic [19:0] fs;
  logic [31:0] lambda;
  logic [30:0] pinit;
  logic [30:0] linit;

  // Estimator state.
  logic                 primed;
  logic signed [31:0]   prev_id;
  logic signed [SW-1:0] th0, th1, p00, p01, p10, p11;
  logic signed [31:0]   ind_used;

  // Latched sample and intermediates of the update.
  logic signed [31:0] vd, id, iq, w;
  logic signed [63:0] phi1, tq, y, acc, e, pp0, pp1, q0, q1, den, k0, k1;

  mrirls_pkg::seq_state_t state, state_next;
  mrirls_pkg::step_t      step;
  mrirls_pkg::alu_req_t   req;
  mrirls_pkg::alu_rsp_t   rsp;

  logic               accept;
  logic signed [63:0] phi0, lam, r, sum, den_raw;
  logic signed [32:0] did;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == mrirls_pkg::ST_IDLE);
  assign phi0     = {{32{id[31]}}, id};
  assign lam      = (lambda == 32'd0) ? 64'sd1 : {32'd0, lambda};
  assign r        = rsp.value;
  assign sum      = mrirls_pkg::sat_add(acc, r);
  assign den_raw  = mrirls_pkg::sat_add({48'd0, lambda[31:16]}, sum);
  assign did      = {id[31], id} - {prev_id[31], prev_id};

  mrirls_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Operands of each step of the update sequence.
  always_comb begin
    req.start     = (state == mrirls_pkg::ST_ISSUE);
    req.is_div    = 1'b0;
    req.sat_state = 1'b0;
    req.shift     = 6'd16;
    req.a         = 64'sd0;
    req.b         = 64'sd0;
    case (step)
      mrirls_pkg::STEP_PHI1: begin
        req.a = {{31{did[32]}}, did};
        req.b = {44'd0, fs};
        req.shift = 6'd0;
        req.sat_state = 1'b1;
      end
      mrirls_pkg::STEP_T: begin
        req.a = {{32{w[31]}}, w};
        req.b = {{32{ind_used[31]}}, ind_used};
        req.shift = 6'd24;
      end
      mrirls_pkg::STEP_Y: begin
        req.a = tq;
        req.b = {{32{iq[31]}}, iq};
      end
      mrirls_pkg::STEP_PRED0: begin
        req.a = phi0; req.b = mrirls_pkg::ext_state(th0); req.shift = 6'd24;
      end
      mrirls_pkg::STEP_ERR: begin
        req.a = phi1; req.b = mrirls_pkg::ext_state(th1); req.shift = 6'd24;
      end
      mrirls_pkg::STEP_PP00: begin req.a = mrirls_pkg::ext_state(p00); req.b = phi0; end
      mrirls_pkg::STEP_PP0:  begin req.a = mrirls_pkg::ext_state(p01); req.b = phi1; end
      mrirls_pkg::STEP_PP10: begin req.a = mrirls_pkg::ext_state(p10); req.b = phi0; end
      mrirls_pkg::STEP_PP1:  begin req.a = mrirls_pkg::ext_state(p11); req.b = phi1; end
      mrirls_pkg::STEP_Q00:  begin req.a = phi0; req.b = mrirls_pkg::ext_state(p00); end
      mrirls_pkg::STEP_Q0:   begin req.a = phi1; req.b = mrirls_pkg::ext_state(p10); end
      mrirls_pkg::STEP_Q10:  begin req.a = phi0; req.b = mrirls_pkg::ext_state(p01); end
      mrirls_pkg::STEP_Q1:   begin req.a = phi1; req.b = mrirls_pkg::ext_state(p11); end
      mrirls_pkg::STEP_S0:   begin req.a = phi0; req.b = pp0; end
      mrirls_pkg::STEP_DEN:  begin req.a = phi1; req.b = pp1; end
      mrirls_pkg::STEP_K0: begin
        req.a = pp0; req.b = den; req.shift = 6'd32; req.is_div = 1'b1;
      end
      mrirls_pkg::STEP_TH0: begin req.a = k0; req.b = e; req.shift = 6'd24; end
      mrirls_pkg::STEP_K1: begin
        req.a = pp1; req.b = den; req.shift = 6'd32; req.is_div = 1'b1;
      end
      mrirls_pkg::STEP_TH1: begin req.a = k1; req.b = e; req.shift = 6'd24; end
      mrirls_pkg::STEP_M00: begin req.a = k0; req.b = q0; req.shift = 6'd32; end
      mrirls_pkg::STEP_M01: begin req.a = k0; req.b = q1; req.shift = 6'd32; end
      mrirls_pkg::STEP_M10: begin req.a = k1; req.b = q0; req.shift = 6'd32; end
      mrirls_pkg::STEP_M11: begin req.a = k1; req.b = q1; req.shift = 6'd32; end
      mrirls_pkg::STEP_P00, mrirls_pkg::STEP_P01,
      mrirls_pkg::STEP_P10, mrirls_pkg::STEP_P11: begin
        req.a = acc; req.b = lam; req.shift = 6'd32;
        req.is_div = 1'b1; req.sat_state = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer: issue a step, wait for the shared unit, move on.
  always_comb begin
    state_next = state;
    case (state)
      mrirls_pkg::ST_IDLE:  if (accept && primed) state_next = mrirls_pkg::ST_ISSUE;
      mrirls_pkg::ST_ISSUE: state_next = mrirls_pkg::ST_WAIT;
      mrirls_pkg::ST_WAIT: if (rsp.done) begin
        state_next = (step == mrirls_pkg::STEP_P11) ? mrirls_pkg::ST_OUT
                                                     : mrirls_pkg::ST_ISSUE;
      end
      mrirls_pkg::ST_OUT: if (!m_tvalid || m_tready) state_next = mrirls_pkg::ST_IDLE;
      default: state_next = mrirls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mrirls_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mrirls_pkg::ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Configuration, estimator state and the update results.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs       <= 20'd20000;
      lambda   <= 32'd4273492460;
      pinit    <= 31'd65536000;
      linit    <= 31'd16777;
      primed   <= 1'b0;
      prev_id  <= 32'sd0;
      th0      <= '0;
      th1      <= '0;
      p00      <= SW'(65536000);
      p01      <= '0;
      p10      <= '0;
      p11      <= SW'(65536000);
      ind_used <= 32'sd16777;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrirls_pkg::CFG_SAMPLE_RATE: fs <= cfg_data[19:0];
        mrirls_pkg::CFG_FORGETTING:  lambda <= cfg_data;
        mrirls_pkg::CFG_INIT_COV, mrirls_pkg::CFG_INIT_IND: begin
          // Either initial value restarts the estimator from scratch.
          primed  <= 1'b0;
          prev_id <= 32'sd0;
          th0     <= '0;
          th1     <= '0;
          p01     <= '0;
          p10     <= '0;
          if (cfg_addr == mrirls_pkg::CFG_INIT_COV) begin
            pinit    <= cfg_data[30:0];
            p00      <= SW'(cfg_data[30:0]);
            p11      <= SW'(cfg_data[30:0]);
            ind_used <= {1'b0, linit};
          end else begin
            linit    <= cfg_data[30:0];
            p00      <= SW'(pinit);
            p11      <= SW'(pinit);
            ind_used <= {1'b0, cfg_data[30:0]};
          end
        end
        default: ;
      endcase
    end else begin
      if (accept && !primed) begin
        primed  <= 1'b1;
        prev_id <= s_tdata[63:32];
      end
      if (state == mrirls_pkg::ST_WAIT && rsp.done) begin
        case (step)
          mrirls_pkg::STEP_TH0: th0 <= mrirls_pkg::clamp_state(
                                   mrirls_pkg::sat_add(mrirls_pkg::ext_state(th0), r));
          mrirls_pkg::STEP_TH1: th1 <= mrirls_pkg::clamp_state(
                                   mrirls_pkg::sat_add(mrirls_pkg::ext_state(th1), r));
          mrirls_pkg::STEP_P00: p00 <= r[SW-1:0];
          mrirls_pkg::STEP_P01: p01 <= r[SW-1:0];
          mrirls_pkg::STEP_P10: p10 <= r[SW-1:0];
          mrirls_pkg::STEP_P11: begin
            p11      <= r[SW-1:0];
            prev_id  <= id;
            ind_used <= mrirls_pkg::clamp32(mrirls_pkg::ext_state(th1));
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of one update; they need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      vd   <= s_tdata[31:0];
      id   <= s_tdata[63:32];
      iq   <= s_tdata[95:64];
      w    <= s_tdata[127:96];
      step <= mrirls_pkg::STEP_PHI1;
    end
    if (state == mrirls_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {ind_used, mrirls_pkg::clamp32(mrirls_pkg::ext_state(th0))};
    end
    if (state == mrirls_pkg::ST_WAIT && rsp.done) begin
      if (step != mrirls_pkg::STEP_P11) step <= mrirls_pkg::step_t'(step + 5'd1);
      case (step)
        mrirls_pkg::STEP_PHI1:  phi1 <= r;
        mrirls_pkg::STEP_T:     tq <= r;
        mrirls_pkg::STEP_Y:     y <= mrirls_pkg::sat_add({{32{vd[31]}}, vd}, r);
        mrirls_pkg::STEP_PRED0, mrirls_pkg::STEP_PP00, mrirls_pkg::STEP_PP10,
        mrirls_pkg::STEP_Q00, mrirls_pkg::STEP_Q10, mrirls_pkg::STEP_S0: acc <= r;
        mrirls_pkg::STEP_ERR:   e <= mrirls_pkg::sat_sub(y, sum);
        mrirls_pkg::STEP_PP0:   pp0 <= sum;
        mrirls_pkg::STEP_PP1:   pp1 <= sum;
        mrirls_pkg::STEP_Q0:    q0 <= sum;
        mrirls_pkg::STEP_Q1:    q1 <= sum;
        // A denominator that is not positive is raised to one LSB.
        mrirls_pkg::STEP_DEN:   den <= (den_raw < 64'sd1) ? 64'sd1 : den_raw;
        mrirls_pkg::STEP_K0:    k0 <= r;
        mrirls_pkg::STEP_K1:    k1 <= r;
        mrirls_pkg::STEP_M00:   acc <= mrirls_pkg::sat_sub(mrirls_pkg::ext_state(p00), r);
        mrirls_pkg::STEP_M01:   acc <= mrirls_pkg::sat_sub(mrirls_pkg::ext_state(p01), r);
        mrirls_pkg::STEP_M10:   acc <= mrirls_pkg::sat_sub(mrirls_pkg::ext_state(p10), r);
        mrirls_pkg::STEP_M11:   acc <= mrirls_pkg::sat_sub(mrirls_pkg::ext_state(p11), r);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mrirls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrirls_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_resistance_inductance_rls_assert.svh"

module mrirls_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata
);

  `MRIRLS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `MRIRLS_ASSERT_NXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared right after a request")
  `MRIRLS_ASSERT_IMP(a_result_from_busy, $rose(m_tvalid), $past(!s_tready), "result appeared while the block was idle")

endmodule

bind motor_resistance_inductance_rls mrirls_port_checker u_mrirls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
